[hw/rtl/wlhf_pkg.sv]
// ----------------------------------------------------------------------------
// wlhf_pkg
// Shared types, constants and the arctangent table of the wall line fusion.
// ----------------------------------------------------------------------------
package wlhf_pkg;

  localparam int MAX_LINES    = 64;
  localparam int USED_W       = 7;
  localparam int THR_W        = 14;
  localparam int CORDIC_STEPS = 20;
  localparam int CNT_W        = 6;
  localparam int CW           = 36;   // cordic x / y
  localparam int ZW           = 26;   // cordic angle, degrees Q16
  localparam int HDW          = 27;   // heading in degrees Q16
  localparam int AW           = 28;   // wall angle and its error
  localparam int WT_W         = 23;
  localparam int WHT_W        = 44;
  localparam int HC_W         = 24;
  localparam int NUM_W        = 46;
  localparam int DIV_STEPS    = NUM_W;
  localparam int DEN_W        = WT_W + 1;

  localparam logic [16:0] KEEP_MIN = 17'd52429;
  localparam logic [16:0] W_SAT    = 17'd65536;

  localparam logic signed [AW-1:0] DEG_360 = 28'sd23592960;
  localparam logic signed [AW-1:0] DEG_270 = 28'sd17694720;
  localparam logic signed [AW-1:0] DEG_180 = 28'sd11796480;
  localparam logic signed [AW-1:0] DEG_90  = 28'sd5898240;

  localparam logic signed [42:0] RAD_TO_DEG = 43'sd3754936;
  localparam logic signed [47:0] DEG_TO_RAD = 48'sd292818;
  localparam logic signed [47:0] HEAD_LIM   = 48'sd411775;

  typedef struct packed {
    logic signed [23:0]    slope;
    logic signed [19:0]    head;
    logic signed [HDW-1:0] hdeg;
    logic                  keep;
    logic [16:0]           weight;
    logic                  last;
  } wlhf_entry_t;

  typedef enum logic [2:0] {
    B_IDLE, B_CORDIC, B_CLASS, B_ERR, B_ACC, B_PREP, B_DIV, B_EMIT
  } wlhf_bstate_t;

  function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740967;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [AW-1:0] abs_a(input logic signed [AW-1:0] v);
    return (v < 0) ? -v : v;
  endfunction

endpackage

[hw/rtl/wall_line_heading_fusion_core.sv]
// ----------------------------------------------------------------------------
// wall_line_heading_fusion_core
// Fuse lidar wall lines of one scan into an R squared weighted heading.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | slope, fit quality, heading, last
//  out_    | output    | out_valid / out_ready| corrected heading, lines used, valid
//  cfg_    | input     | APB, pready tied 1   | angle_threshold at byte address 0
//
// Sequence: a line that fails the fit test, or arrives once 64 lines are in,
//   is dropped while the back is idle; a kept line runs the iterative
//   arctangent, axis test, error and accumulate states. A last line then adds
//   the bit-serial divider, or skips it when no line of the scan was used.
// Reset: synchronous, active low; clears queue, sequencer, sums and out valid.
// Stalls: a two-entry queue lets the front take items while the back works;
//   the back waits only to load the output register while a result is held.
// ----------------------------------------------------------------------------
module wall_line_heading_fusion_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_line_slope,
  input  logic [16:0]        in_fit_quality,
  input  logic signed [19:0] in_heading_estimate,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [19:0] out_corrected_heading,
  output logic [6:0]         out_lines_used,
  output logic               out_valid_res,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  wlhf_pkg::wlhf_entry_t push_ent, head_ent;
  logic                  push, pop, q_not_full, q_not_empty;
  logic [13:0]           thr_r;

  // Register file: one word, the angle threshold; other words read as zero.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {18'd0, thr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 14'd2560;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      thr_r <= cfg_pwdata[13:0];
    end
  end

  // Front: classify and convert heading, push into the queue
  wlhf_front u_front (
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_line_slope       (in_line_slope),
    .in_fit_quality      (in_fit_quality),
    .in_heading_estimate (in_heading_estimate),
    .in_last             (in_last),
    .q_ready             (q_not_full),
    .q_push              (push),
    .q_entry             (push_ent)
  );

  wlhf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_data   (push_ent),
    .not_full  (q_not_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .rd_data   (head_ent)
  );

  // Back: arctangent, axis test, accumulate, divide, hold the result
  wlhf_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .threshold             (thr_r),
    .q_not_empty           (q_not_empty),
    .q_data                (head_ent),
    .q_pop                 (pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_corrected_heading (out_corrected_heading),
    .out_lines_used        (out_lines_used),
    .out_valid_res         (out_valid_res)
  );

endmodule

[hw/rtl/wlhf_front.sv]
// ----------------------------------------------------------------------------
// wlhf_front
// Accept items, classify by fit quality and convert the heading to degrees.
// ----------------------------------------------------------------------------
module wlhf_front (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [23:0]    in_line_slope,
  input  logic [16:0]           in_fit_quality,
  input  logic signed [19:0]    in_heading_estimate,
  input  logic                  in_last,
  input  logic                  q_ready,
  output logic                  q_push,
  output wlhf_pkg::wlhf_entry_t q_entry
);

  logic signed [42:0] hprod;

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  always_comb begin
    hprod = 43'(in_heading_estimate) * wlhf_pkg::RAD_TO_DEG;
    q_entry.slope  = in_line_slope;
    q_entry.head   = in_heading_estimate;
    q_entry.hdeg   = wlhf_pkg::HDW'((hprod + 43'sd32768) >>> 16);
    q_entry.keep   = (in_fit_quality >= wlhf_pkg::KEEP_MIN);
    q_entry.weight = (in_fit_quality > wlhf_pkg::W_SAT) ? wlhf_pkg::W_SAT : in_fit_quality;
    q_entry.last   = in_last;
  end

endmodule

[hw/rtl/wlhf_queue.sv]
// ----------------------------------------------------------------------------
// wlhf_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module wlhf_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  wlhf_pkg::wlhf_entry_t wr_data,
  output logic                  not_full,
  input  logic                  pop,
  output logic                  not_empty,
  output wlhf_pkg::wlhf_entry_t rd_data
);

  wlhf_pkg::wlhf_entry_t ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign not_full  = (cnt_r != 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign rd_data   = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

[hw/rtl/wlhf_back.sv]
// ----------------------------------------------------------------------------
// wlhf_back
// Run the arctangent, axis test, weighted accumulation and final division.
// ----------------------------------------------------------------------------
module wlhf_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [13:0]           threshold,
  input  logic                  q_not_empty,
  input  wlhf_pkg::wlhf_entry_t q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [19:0]    out_corrected_heading,
  output logic [6:0]            out_lines_used,
  output logic                  out_valid_res
);

  localparam int CW = wlhf_pkg::CW;
  localparam int AW = wlhf_pkg::AW;

  wlhf_pkg::wlhf_bstate_t state_r, state_nxt;
  wlhf_pkg::wlhf_entry_t  cur_r;

  logic [wlhf_pkg::CNT_W-1:0]        cnt_r;
  logic signed [CW-1:0]              x_r, y_r;
  logic signed [wlhf_pkg::ZW-1:0]    z_r;
  logic signed [AW-1:0]              err_r;
  logic                              use_r;
  logic signed [wlhf_pkg::HC_W-1:0]  hc_r;
  logic [wlhf_pkg::USED_W-1:0]       used_r;
  logic [wlhf_pkg::WT_W-1:0]         wt_r;
  logic signed [wlhf_pkg::WHT_W-1:0] wht_r;
  logic [wlhf_pkg::NUM_W-1:0]        quo_r;
  logic [wlhf_pkg::DEN_W:0]          rem_r;
  logic                              neg_r;
  logic                              out_valid_r;
  logic signed [19:0]                out_head_r;
  logic [6:0]                        out_used_r;
  logic                              out_res_r;

  logic                 take, room, load_out, start_line;
  logic signed [CW-1:0] dx, dy;
  logic signed [AW-1:0] a_sum, a_mod, thr, d90, d270, d0, d180, d360, err_c;
  logic                 vert, horz;
  logic signed [47:0]   eprod, mean;
  logic signed [41:0]   wprod;
  logic signed [wlhf_pkg::NUM_W-1:0] num;
  logic [wlhf_pkg::DEN_W:0]          rem_s;
  logic [wlhf_pkg::DEN_W:0]          den;

  // Datapath terms
  always_comb begin
    dx    = y_r >>> cnt_r[4:0];
    dy    = x_r >>> cnt_r[4:0];
    a_sum = AW'(z_r) + AW'(cur_r.hdeg);
    priority if (a_sum < -wlhf_pkg::DEG_360) a_mod = a_sum + (wlhf_pkg::DEG_360 <<< 1);
    else if (a_sum < 0)                      a_mod = a_sum + wlhf_pkg::DEG_360;
    else if (a_sum >= wlhf_pkg::DEG_360)     a_mod = a_sum - wlhf_pkg::DEG_360;
    else                                     a_mod = a_sum;
    thr  = $signed({6'b0, threshold, 8'b0});
    d90  = wlhf_pkg::abs_a(wlhf_pkg::DEG_90 - a_mod);
    d270 = wlhf_pkg::abs_a(wlhf_pkg::DEG_270 - a_mod);
    d0   = wlhf_pkg::abs_a(a_mod);
    d180 = wlhf_pkg::abs_a(wlhf_pkg::DEG_180 - a_mod);
    d360 = wlhf_pkg::abs_a(wlhf_pkg::DEG_360 - a_mod);
    vert = (d90 < thr) || (d270 < thr);
    horz = (d0 < thr) || (d180 < thr) || (d360 < thr);
    priority if (vert) err_c = (d90 < d270) ? wlhf_pkg::DEG_90 - a_mod
                                            : wlhf_pkg::DEG_270 - a_mod;
    else if (d0 < d180)   err_c = a_mod;
    else if (d360 < d180) err_c = a_mod - wlhf_pkg::DEG_360;
    else                  err_c = wlhf_pkg::DEG_180 - a_mod;
    eprod = 48'(err_r) * wlhf_pkg::DEG_TO_RAD;
    wprod = $signed({1'b0, cur_r.weight}) * 42'(hc_r);
    num   = (wlhf_pkg::NUM_W'(wht_r) <<< 1) + $signed(wlhf_pkg::NUM_W'(wt_r));
    den   = {1'b0, wt_r, 1'b0};
    rem_s = {rem_r[wlhf_pkg::DEN_W-1:0], quo_r[wlhf_pkg::NUM_W-1]};
    mean  = neg_r ? -($signed({2'b0, quo_r}) + 48'(rem_r != '0)) : $signed({2'b0, quo_r});
    if (mean > wlhf_pkg::HEAD_LIM)  mean = wlhf_pkg::HEAD_LIM;
    if (mean < -wlhf_pkg::HEAD_LIM) mean = -wlhf_pkg::HEAD_LIM;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wlhf_pkg::B_IDLE: begin
        if (q_not_empty) begin
          if (q_data.keep && (used_r < wlhf_pkg::USED_W'(wlhf_pkg::MAX_LINES)))
            state_nxt = wlhf_pkg::B_CORDIC;
          else if (q_data.last) state_nxt = wlhf_pkg::B_PREP;
        end
      end
      wlhf_pkg::B_CORDIC:
        if (cnt_r == wlhf_pkg::CNT_W'(wlhf_pkg::CORDIC_STEPS - 1)) state_nxt = wlhf_pkg::B_CLASS;
      wlhf_pkg::B_CLASS: state_nxt = wlhf_pkg::B_ERR;
      wlhf_pkg::B_ERR:   state_nxt = wlhf_pkg::B_ACC;
      wlhf_pkg::B_ACC:   state_nxt = cur_r.last ? wlhf_pkg::B_PREP : wlhf_pkg::B_IDLE;
      wlhf_pkg::B_PREP:  state_nxt = (used_r == '0) ? wlhf_pkg::B_EMIT : wlhf_pkg::B_DIV;
      wlhf_pkg::B_DIV:
        if (cnt_r == wlhf_pkg::CNT_W'(wlhf_pkg::DIV_STEPS - 1)) state_nxt = wlhf_pkg::B_EMIT;
      wlhf_pkg::B_EMIT:  if (room) state_nxt = wlhf_pkg::B_IDLE;
      default:           state_nxt = wlhf_pkg::B_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    room       = !out_valid_r || out_ready;
    take       = (state_r == wlhf_pkg::B_IDLE) && q_not_empty;
    start_line = take && q_data.keep && (used_r < wlhf_pkg::USED_W'(wlhf_pkg::MAX_LINES));
    load_out   = (state_r == wlhf_pkg::B_EMIT) && room;
    q_pop      = take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= wlhf_pkg::B_IDLE;
    else        state_r <= state_nxt;
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (take) cur_r <= q_data;
    unique case (state_r)
      wlhf_pkg::B_CORDIC: begin
        cnt_r <= cnt_r + 1'b1;
        if (!y_r[CW-1]) begin
          x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + wlhf_pkg::atan_tab(cnt_r[4:0]);
        end else begin
          x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - wlhf_pkg::atan_tab(cnt_r[4:0]);
        end
      end
      wlhf_pkg::B_CLASS: begin
        err_r <= err_c;
        use_r <= vert || horz;
      end
      wlhf_pkg::B_ERR:
        hc_r <= wlhf_pkg::HC_W'(cur_r.head) - wlhf_pkg::HC_W'((eprod + 48'sd8388608) >>> 24);
      wlhf_pkg::B_PREP: begin
        neg_r <= num[wlhf_pkg::NUM_W-1];
        quo_r <= num[wlhf_pkg::NUM_W-1] ? -num : num;
        rem_r <= '0;
        cnt_r <= '0;
      end
      wlhf_pkg::B_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        if (rem_s >= den) begin
          rem_r <= rem_s - den;
          quo_r <= {quo_r[wlhf_pkg::NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_s;
          quo_r <= {quo_r[wlhf_pkg::NUM_W-2:0], 1'b0};
        end
      end
      default: begin
        if (start_line) begin
          x_r   <= CW'(36'sd16777216);
          y_r   <= CW'(q_data.slope) <<< 8;
          z_r   <= '0;
          cnt_r <= '0;
        end
      end
    endcase
    if (load_out) begin
      out_head_r <= (used_r == '0) ? 20'sd0 : 20'(mean);
      out_used_r <= used_r;
      out_res_r  <= (used_r != '0);
    end
  end

  // Accumulators and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      wt_r        <= '0;
      wht_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == wlhf_pkg::B_ACC) && use_r) begin
        used_r <= used_r + 1'b1;
        wt_r   <= wt_r + wlhf_pkg::WT_W'(cur_r.weight);
        wht_r  <= wht_r + wlhf_pkg::WHT_W'(wprod);
      end else if (load_out) begin
        used_r <= '0;
        wt_r   <= '0;
        wht_r  <= '0;
      end
      if (load_out)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_corrected_heading = out_head_r;
  assign out_lines_used        = out_used_r;
  assign out_valid_res         = out_res_r;

endmodule

[hw/rtl/wlhf_checker.sv]
// ----------------------------------------------------------------------------
// wlhf_checker
// Port-level checks of the result channel and of cfg_pready, bound to the top level.
// ----------------------------------------------------------------------------
module wlhf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [19:0] out_corrected_heading,
  input logic [6:0]         out_lines_used,
  input logic               out_valid_res,
  input logic               cfg_pready
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_corrected_heading)
      && $stable(out_lines_used) && $stable(out_valid_res))
    else $error("result changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_corrected_heading == 20'sd0 && out_lines_used == 7'd0)
    else $error("empty scan result not zero");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> out_lines_used != 7'd0 && out_lines_used <= 7'd64)
    else $error("lines used out of range");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_corrected_heading <= 20'sd411775
      && out_corrected_heading >= -20'sd411775)
    else $error("heading out of range");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready low");

endmodule

bind wall_line_heading_fusion_core wlhf_checker u_wlhf_checker (.*);

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drive scans of wall lines into the heading fusion core and compare every
// scan result against a bit-exact fixed-point predictor of the fusion.
// ----------------------------------------------------------------------------

// Scoreboard: holds its own copy of the threshold and the scan sums, predicts
// the result of each scan from its accepted lines and compares the results that come out.
class scan_scoreboard;
  typedef struct packed {
    logic signed [19:0] heading;
    logic [6:0]         used;
    logic               ok;
  } scan_result_t;

  scan_result_t        pending[$];
  logic [13:0]         threshold;
  int unsigned         line_cnt;
  longint              wsum;
  longint              whsum;
  int unsigned         mismatches;

  function void clear_sums();
    line_cnt = 0;
    wsum = 0;
    whsum = 0;
  endfunction

  function longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function longint div_floor(longint n, longint d);
    if (n >= 0) return n / d;
    return -(((-n) + d - 1) / d);
  endfunction

  function longint abs_l(longint v);
    return v < 0 ? -v : v;
  endfunction

  // 20 step vectoring arctangent, degrees Q16.
  function longint atan_q16(longint slope);
    longint tab[20];
    longint x, y, z, dx, dy;
    tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
            14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
    x = 64'sd1 << 24;
    y = slope * 256;
    z = 0;
    for (int i = 0; i < 20; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += tab[i];
      end else begin
        x -= dx; y += dy; z -= tab[i];
      end
    end
    return z;
  endfunction

  function void note_line(logic signed [23:0] slope, logic [16:0] fq,
                          logic signed [19:0] head, logic last);
    longint thr, hdeg, a, d90, d270, d0, d180, d360, err, w, erad, mean;
    bit take;
    scan_result_t r;
    take = 0;
    err = 0;
    if (fq >= 52429 && line_cnt < 64) begin
      thr = longint'(threshold) * 256;
      hdeg = shr_floor(longint'(head) * 3754936 + 32768, 16);
      a = atan_q16(longint'(slope)) + hdeg;
      a -= div_floor(a, 23592960) * 23592960;
      d90 = abs_l(5898240 - a);
      d270 = abs_l(17694720 - a);
      d0 = abs_l(a);
      d180 = abs_l(11796480 - a);
      d360 = abs_l(23592960 - a);
      if (d90 < thr || d270 < thr) begin
        err = d90 < d270 ? 5898240 - a : 17694720 - a;
        take = 1;
      end else if (d0 < thr || d180 < thr || d360 < thr) begin
        if (d0 < d180) err = a;
        else if (d360 < d180) err = a - 23592960;
        else err = 11796480 - a;
        take = 1;
      end
      if (take) begin
        w = fq > 65536 ? 65536 : longint'(fq);
        erad = shr_floor(err * 292818 + (64'sd1 << 23), 24);
        wsum += w;
        whsum += w * (longint'(head) - erad);
        line_cnt++;
      end
    end
    if (!last) return;
    if (line_cnt > 0 && wsum > 0) begin
      mean = div_floor(2 * whsum + wsum, 2 * wsum);
      if (mean > 411775) mean = 411775;
      if (mean < -411775) mean = -411775;
      r.heading = mean[19:0];
      r.used = line_cnt[6:0];
      r.ok = 1'b1;
    end else begin
      r = '0;
    end
    pending = {pending, r};
    clear_sums();
  endfunction

  function void check_result(logic signed [19:0] heading, logic [6:0] used,
                             logic ok);
    scan_result_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: heading %0d used %0d valid %0b",
                 heading, used, ok);
      return;
    end
    e = pending.pop_front();
    if (e.heading !== heading || e.used !== used || e.ok !== ok) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: expected heading %0d used %0d valid %0b, got %0d %0d %0b",
                 e.heading, e.used, e.ok, heading, used, ok);
    end
  endfunction
endclass

module testbench;

  localparam logic [2:0] REG_ANGLE_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_UNUSED          = 3'd4;
  localparam longint     CYCLE_LIMIT         = 2000000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [23:0] in_line_slope = '0;
  logic [16:0]        in_fit_quality = '0;
  logic signed [19:0] in_heading_estimate = '0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [19:0] out_corrected_heading;
  logic [6:0]         out_lines_used;
  logic               out_valid_res;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [2:0]         cfg_paddr = '0;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  scan_scoreboard sb;
  int     send_idle_pct = 0;   // sender gap chance, percent
  int     recv_stall_pct = 0;  // receiver stall chance, percent
  int     hold_off = 0;        // long receiver hold-off, in cycles
  longint cycles = 0;

  always #5 clk = ~clk;

  wall_line_heading_fusion_core dut (.*);

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[wall_line_heading_fusion_core] ERROR");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off for a long stretch when asked;
  // check every accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_corrected_heading, out_lines_used, out_valid_res);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one line; hold it until accepted, note it for prediction.
  // Valid stays high into the next line unless the sender idles.
  task automatic send_line(logic signed [23:0] slope, logic [16:0] fq,
                           logic signed [19:0] head, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_line_slope <= slope;
    in_fit_quality <= fq;
    in_heading_estimate <= head;
    in_last <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_line(slope, fq, head, last);
  endtask

  // APB write: setup then access cycle.
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Drop valid, drain every prediction, then let a trailing dropped line finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // Threshold write at idle; the predictor follows the written value.
  task automatic set_threshold(logic [13:0] thr);
    wait_idle();
    write_reg(REG_ANGLE_THRESHOLD, {18'h3ffff, thr});
    sb.threshold = thr;
  endtask

  // Random line: mostly kept lines near an axis, some rejects and extremes.
  task automatic random_line(bit last);
    logic signed [23:0] slope;
    logic [16:0]        fq;
    logic signed [19:0] head;
    int r;
    r = $urandom_range(99);
    if (r < 10) slope = 24'($urandom);
    else if (r < 20) slope = $urandom_range(1, 0) ? 24'sh7fffff : -24'sd8388608;
    else slope = 24'($signed($urandom_range(262144)) - 131072);
    r = $urandom_range(99);
    if (r < 15) fq = 17'($urandom_range(52428));
    else if (r < 25) fq = 17'($urandom_range(131071, 65536));
    else fq = 17'($urandom_range(65536, 52429));
    r = $urandom_range(99);
    if (r < 15) head = 20'($signed($urandom_range(823550)) - 411775);
    else if (r < 25) head = 20'($urandom);
    else head = 20'($signed($urandom_range(20000)) - 10000 +
                    ($urandom_range(3) * 102944) - 154416);
    send_line(slope, fq, head, last);
  endtask

  task automatic random_scans(int lines);
    int n;
    while (lines > 0) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(80, 60) : $urandom_range(12, 1);
      for (int i = 0; i < n; i++) random_line(i == n - 1);
      lines -= n;
    end
  endtask

  initial begin
    sb = new();
    sb.threshold = 14'd2560;
    sb.clear_sums();
    sb.mismatches = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, rejects, lone last, empty scan.
    send_line(24'sd0, 17'd65536, 20'sd0, 1'b1);
    send_line(24'sh7fffff, 17'd131071, 20'sd411775, 1'b0);
    send_line(-24'sd8388608, 17'd52429, -20'sd411775, 1'b0);
    send_line(24'sd65536, 17'd52428, 20'sd0, 1'b1);        // rejected fit
    send_line(24'sd1000, 17'd0, 20'sd0, 1'b1);             // no line used
    send_line(24'sd65536, 17'd65536, 20'sd0, 1'b0);        // 45 deg, off axis
    send_line(-24'sd3000, 17'd60000, -20'sd5000, 1'b1);    // near 360
    send_line(24'sd2000, 17'd65536, 20'sd205887, 1'b1);    // near 180
    send_line(24'sd500, 17'd65536, 20'sd102944, 1'b1);     // near 90
    send_line(24'sd500, 17'd65536, -20'sd102944, 1'b1);    // near 270
    // Too many lines: 70 kept lines in one scan.
    for (int i = 0; i < 70; i++) send_line(24'sd100, 17'd65536, 20'sd300, i == 69);
    // Invalid register index must not disturb the threshold.
    wait_idle();
    write_reg(REG_UNUSED, 32'hffff_ffff);
    set_threshold(14'd11520);   // 45 degrees: vertical takes priority
    send_line(24'sd65536, 17'd65536, 20'sd0, 1'b0);
    send_line(24'sd30000, 17'd65536, 20'sd1000, 1'b1);
    set_threshold(14'd0);
    send_line(24'sd0, 17'd65536, 20'sd0, 1'b1);
    set_threshold(14'd16383 & 14'h3fff);
    send_line(24'sd0, 17'd65536, 20'sd0, 1'b1);
    set_threshold(14'd2560);

    // Random phases with different idling.
    random_scans(75);
    send_idle_pct = 59;
    random_scans(75);
    send_idle_pct = 0; recv_stall_pct = 59;
    set_threshold(14'd768);
    random_scans(75);
    send_idle_pct = 31; recv_stall_pct = 31;
    set_threshold(14'd5000);
    random_scans(75);
    // Long hold-off while the sender keeps offering lines.
    send_idle_pct = 0; recv_stall_pct = 0;
    set_threshold(14'd2560);
    hold_off = 3000;
    for (int i = 0; i < 40; i++) random_line(1'b1);
    random_scans(75);

    wait_idle();
    if (sb.mismatches == 0)
      $display("[wall_line_heading_fusion_core] OK");
    else
      $display("[wall_line_heading_fusion_core] ERROR");
    $finish;
  end
endmodule
